// ===== hw/rtl/pli_pkg.sv =====
// Shared constants, types and arithmetic widths of the pose linear interpolator.
package pli_pkg;

  // Configuration of the leg set and the coordinate stores.
  localparam int LEG_COUNT   = 4;
  localparam int STORE_DEPTH = 12;
  localparam int COORD_COUNT = (LEG_COUNT * 3 > STORE_DEPTH) ? STORE_DEPTH : LEG_COUNT * 3;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths of the input and result words.
  localparam int INDEX_W = 4;
  localparam int COORD_W = 16;
  localparam int DELTA_W = COORD_W + 1;
  localparam int POS_W   = 16;
  localparam int ENTRY_W = COORD_W + DELTA_W;

  // Operation codes of an input word.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Fixed-point constants.
  localparam logic [POS_W-1:0] MAX_U16 = 16'hFFFF;
  localparam int DEC4        = 10000;
  localparam int PCT_W       = 14;
  localparam int SCALED_W    = 30;
  localparam int PROD_W      = 32;
  localparam int MAG_W       = 30;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 17;
  localparam int RECIP       = (2 ** RECIP_SHIFT) / DEC4;
  localparam int QUOT_W      = 17;

  // One read issued by the sequencer, with the tag that travels down the pipeline.
  typedef struct packed {
    logic               vld;
    logic [ADDR_W-1:0]  index;
    logic               last;
    logic               done;
    logic [PCT_W-1:0]   percent;
    logic               live;
  } pli_issue_t;

endpackage

// ===== hw/rtl/pli_in_if.sv =====
// Input channel carrying load and step words.
interface pli_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [pli_pkg::INDEX_W-1:0]   coord_index;
  logic signed [pli_pkg::COORD_W-1:0] start_value;
  logic signed [pli_pkg::COORD_W-1:0] end_value;
  logic [pli_pkg::POS_W-1:0]     stride;

  modport source (output valid, op, coord_index, start_value, end_value, stride,
                  input ready);
  modport sink   (input valid, op, coord_index, start_value, end_value, stride,
                  output ready);
endinterface

// ===== hw/rtl/pli_out_if.sv =====
// Output channel carrying interpolated coordinate words.
interface pli_out_if;
  logic                          valid;
  logic                          ready;
  logic [pli_pkg::INDEX_W-1:0]   out_index;
  logic signed [pli_pkg::COORD_W-1:0] out_value;
  logic                          move_done;
  logic                          last;

  modport source (output valid, out_index, out_value, move_done, last, input ready);
  modport sink   (input valid, out_index, out_value, move_done, last, output ready);
endinterface

// ===== hw/rtl/pli_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pli_seq.sv =====
// Sequencer: move position, percent of the move, store writes and the read sweep.
module pli_seq (
  input  logic                        clk,
  input  logic                        rst,
  pli_in_if.sink                      in_ch,
  input  logic                        adv,
  output pli_pkg::pli_issue_t         issue,
  output logic                        ram_we,
  output logic [pli_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [pli_pkg::ENTRY_W-1:0] ram_wdata,
  output logic                        ram_re,
  output logic [pli_pkg::ADDR_W-1:0]  ram_raddr
);

  typedef enum logic [1:0] {IDLE, SCALE, DIVIDE, SWEEP} state_t;

  state_t                             state;
  logic [pli_pkg::POS_W-1:0]          position;
  logic [pli_pkg::SCALED_W-1:0]       scaled;
  logic [pli_pkg::PCT_W-1:0]          percent;
  logic                               done;
  logic [pli_pkg::ADDR_W-1:0]         cnt;
  logic [pli_pkg::STORE_DEPTH-1:0]    live_bits;

  logic                               accept;
  logic                               load_hit;
  logic [pli_pkg::POS_W:0]            pos_sum;
  logic [pli_pkg::POS_W-1:0]          position_next;
  logic [pli_pkg::DELTA_W-1:0]        delta;
  logic [pli_pkg::PCT_W-1:0]          quot0;
  logic [pli_pkg::POS_W:0]            rem0;
  logic                               last_read;

  assign in_ch.ready = (state == IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_hit    = (in_ch.op == pli_pkg::OP_LOAD) &&
                       (in_ch.coord_index < pli_pkg::INDEX_W'(pli_pkg::COORD_COUNT));

  // Saturating position update.
  assign pos_sum       = {1'b0, position} + {1'b0, in_ch.stride};
  assign position_next = (pos_sum >= {1'b0, pli_pkg::MAX_U16}) ? pli_pkg::MAX_U16
                                                                : pos_sum[pli_pkg::POS_W-1:0];

  // Store write for a load: start value and end minus start.
  assign delta     = {in_ch.end_value[pli_pkg::COORD_W-1], in_ch.end_value} -
                     {in_ch.start_value[pli_pkg::COORD_W-1], in_ch.start_value};
  assign ram_we    = accept && load_hit;
  assign ram_waddr = in_ch.coord_index[pli_pkg::ADDR_W-1:0];
  assign ram_wdata = {in_ch.start_value, delta};

  // Division by 65535: the high half plus the low half gives the remainder, off by one period.
  assign quot0 = scaled[pli_pkg::SCALED_W-1:pli_pkg::POS_W];
  assign rem0  = {1'b0, scaled[pli_pkg::POS_W-1:0]} + (pli_pkg::POS_W + 1)'(quot0);

  // Read sweep over the stored coordinates.
  assign last_read     = (cnt == pli_pkg::ADDR_W'(pli_pkg::COORD_COUNT - 1));
  assign ram_re        = (state == SWEEP) && adv;
  assign ram_raddr     = cnt;
  assign issue.vld     = (state == SWEEP);
  assign issue.index   = cnt;
  assign issue.last    = last_read;
  assign issue.done    = done;
  assign issue.percent = percent;
  assign issue.live    = live_bits[cnt];

  // State, position and percent registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      position  <= '0;
      live_bits <= '0;
      cnt       <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            if (in_ch.op == pli_pkg::OP_STEP) begin
              position <= position_next;
              state    <= SCALE;
            end else begin
              position <= '0;
              if (load_hit) begin
                live_bits[in_ch.coord_index[pli_pkg::ADDR_W-1:0]] <= 1'b1;
              end
            end
          end
        end
        SCALE: begin
          scaled <= pli_pkg::SCALED_W'(position) * pli_pkg::SCALED_W'(pli_pkg::DEC4);
          done   <= (position == pli_pkg::MAX_U16);
          state  <= DIVIDE;
        end
        DIVIDE: begin
          percent <= quot0 + pli_pkg::PCT_W'(rem0 >= {1'b0, pli_pkg::MAX_U16});
          cnt     <= '0;
          state   <= SWEEP;
        end
        SWEEP: begin
          if (adv) begin
            cnt <= cnt + 1'b1;
            if (last_read) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pli_datapath.sv =====
// Interpolation pipeline: delta times percent, divide by 10000, add start, output register.
module pli_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  pli_pkg::pli_issue_t         issue,
  input  logic [pli_pkg::ENTRY_W-1:0] ram_rdata,
  output logic                        adv,
  pli_out_if.source                   out_ch
);

  // Stage 1 tag, aligned with the registered RAM data.
  pli_pkg::pli_issue_t                s1;

  // Stage 2: signed product.
  logic                               s2_vld;
  logic [pli_pkg::ADDR_W-1:0]         s2_index;
  logic                               s2_last;
  logic                               s2_done;
  logic signed [pli_pkg::COORD_W-1:0] s2_start;
  logic signed [pli_pkg::PROD_W-1:0]  s2_prod;

  // Stage 3: magnitude and approximate quotient.
  logic                               s3_vld;
  logic [pli_pkg::ADDR_W-1:0]         s3_index;
  logic                               s3_last;
  logic                               s3_done;
  logic signed [pli_pkg::COORD_W-1:0] s3_start;
  logic                               s3_neg;
  logic [pli_pkg::MAG_W-1:0]          s3_mag;
  logic [pli_pkg::QUOT_W-1:0]         s3_qa;

  logic                               out_vld;

  logic signed [pli_pkg::COORD_W-1:0] start_v;
  logic signed [pli_pkg::DELTA_W-1:0] delta_v;
  logic signed [pli_pkg::PROD_W-1:0]  delta_ext;
  logic signed [pli_pkg::PROD_W-1:0]  pct_ext;
  logic signed [pli_pkg::PROD_W-1:0]  prod;
  logic                               neg;
  logic [pli_pkg::PROD_W-1:0]         abs_prod;
  logic [pli_pkg::MAG_W+pli_pkg::RECIP_W-1:0] recip_prod;
  logic [pli_pkg::MAG_W-1:0]          back_prod;
  logic [pli_pkg::MAG_W-1:0]          rem;
  logic [pli_pkg::QUOT_W-1:0]         quot;
  logic signed [pli_pkg::QUOT_W:0]    quot_signed;
  logic signed [pli_pkg::QUOT_W:0]    value;

  assign adv = !out_vld || out_ch.ready;

  // Entries never loaded read as zero.
  assign start_v   = s1.live ? ram_rdata[pli_pkg::ENTRY_W-1:pli_pkg::DELTA_W] : '0;
  assign delta_v   = s1.live ? ram_rdata[pli_pkg::DELTA_W-1:0] : '0;
  assign delta_ext = pli_pkg::PROD_W'(delta_v);
  assign pct_ext   = {{(pli_pkg::PROD_W - pli_pkg::PCT_W){1'b0}}, s1.percent};
  assign prod      = delta_ext * pct_ext;

  // Magnitude times the reciprocal of 10000; low by at most one.
  assign neg        = s2_prod[pli_pkg::PROD_W-1];
  assign abs_prod   = neg ? 32'(-s2_prod) : 32'(s2_prod);
  assign recip_prod = (pli_pkg::MAG_W + pli_pkg::RECIP_W)'(abs_prod[pli_pkg::MAG_W-1:0]) *
                      (pli_pkg::MAG_W + pli_pkg::RECIP_W)'(pli_pkg::RECIP);

  // Remainder correction, sign restore and start offset.
  assign back_prod   = pli_pkg::MAG_W'(s3_qa) * pli_pkg::MAG_W'(pli_pkg::DEC4);
  assign rem         = s3_mag - back_prod;
  assign quot        = s3_qa + pli_pkg::QUOT_W'(rem >= pli_pkg::MAG_W'(pli_pkg::DEC4));
  assign quot_signed = s3_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign value       = (pli_pkg::QUOT_W + 1)'(s3_start) + quot_signed;

  assign out_ch.valid = out_vld;

  // Pipeline valid bits and the stage 1 tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      s1      <= issue;
      s2_vld  <= s1.vld;
      s3_vld  <= s2_vld;
      out_vld <= s3_vld;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_index <= s1.index;
      s2_last  <= s1.last;
      s2_done  <= s1.done;
      s2_start <= start_v;
      s2_prod  <= prod;

      s3_index <= s2_index;
      s3_last  <= s2_last;
      s3_done  <= s2_done;
      s3_start <= s2_start;
      s3_neg   <= neg;
      s3_mag   <= abs_prod[pli_pkg::MAG_W-1:0];
      s3_qa    <= recip_prod[pli_pkg::MAG_W+pli_pkg::RECIP_W-1:pli_pkg::RECIP_SHIFT];

      out_ch.out_index <= pli_pkg::INDEX_W'(s3_index);
      out_ch.out_value <= value[pli_pkg::COORD_W-1:0];
      out_ch.move_done <= s3_done;
      out_ch.last      <= s3_last;
    end
  end

endmodule

// ===== hw/rtl/pose_linear_interpolator.sv =====
// Top level of the pose linear interpolator.
// A load word writes one coordinate's start value and end-minus-start difference into a
// 12-entry store and restarts the move at position zero; it produces no result. A step
// word advances the 16-bit position by its stride field, saturating at 65535, forms
// percent = position*10000/65535 in the SCALE and DIVIDE states, then sweeps the store
// one coordinate per cycle while the output is not stalled, through a two-port
// registered-read RAM, emitting LEG_COUNT*3 result words (at most 12) in index order
// after a four-stage arithmetic pipeline. The next input word is accepted once the
// sweep has issued its last read; output back-pressure stalls the sweep. Coordinates
// that were never loaded read as zero.
module pose_linear_interpolator (
  input  logic clk,
  input  logic rst,
  pli_in_if.sink    in_ch,
  pli_out_if.source out_ch
);

  pli_pkg::pli_issue_t          issue;
  logic                         adv;
  logic                         ram_we;
  logic [pli_pkg::ADDR_W-1:0]   ram_waddr;
  logic [pli_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [pli_pkg::ADDR_W-1:0]   ram_raddr;
  logic [pli_pkg::ENTRY_W-1:0]  ram_rdata;

  // Control and position.
  pli_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .adv       (adv),
    .issue     (issue),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // Start and delta store.
  pli_ram #(
    .WIDTH (pli_pkg::ENTRY_W),
    .DEPTH (pli_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Interpolation arithmetic and output register.
  pli_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .ram_rdata (ram_rdata),
    .adv       (adv),
    .out_ch    (out_ch)
  );

endmodule
